FILE: src/swbm_pkg.sv
// ============================================================================
// swbm_pkg: shared types and constants of the single-wire bus master
// Item and result layouts, phase and command codes, timing register set,
// and the CRC-8 update used on received bytes.
// ============================================================================
package swbm_pkg;

    // configuration register file
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_AW    = 5;
    localparam int TICK_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TAIL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_TAIL    = 3'd7;

    // register reset values, listed from the last register to the first
    localparam logic [NUM_CFG-1:0][TICK_W-1:0] CFG_RESET = {
        16'd260, 16'd5000, 16'd140, 16'd2, 16'd40, 16'd100, 16'd5, 16'd2000
    };

    // fixed segment lengths of the discovery sequence
    localparam logic [TICK_W-1:0] REL_TICKS   = 16'd100;
    localparam logic [TICK_W-1:0] PULSE_TICKS = 16'd10;
    localparam logic [TICK_W-1:0] WAIT_TICKS  = 16'd20;

    // operation codes on the item port
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_DISC  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // command class produced by the front end
    typedef enum logic [2:0] {
        K_TICK,
        K_DISC,
        K_START,
        K_WRITE,
        K_READ,
        K_NOP
    } swbm_kind_t;

    // bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HOLD,
        PH_DLOW,
        PH_DREL,
        PH_DPULSE,
        PH_DWAIT,
        PH_DTAIL,
        PH_BLOW,
        PH_BDATA,
        PH_BREC,
        PH_SLOW,
        PH_SWAIT,
        PH_STAIL
    } swbm_phase_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       line_level;
    } swbm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
        logic       present;
        logic [7:0] crc_value;
        logic       cmd_rejected;
    } swbm_result_t;

    // classified entry of the command queue
    typedef struct packed {
        swbm_kind_t kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       line_level;
    } swbm_cmd_t;

    // queue handshake between front and back
    typedef struct packed {
        logic      valid;
        swbm_cmd_t cmd;
    } swbm_queue_t;

    typedef struct packed {
        logic [TICK_W-1:0] start_hold;
        logic [TICK_W-1:0] bit_low;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] recover;
        logic [TICK_W-1:0] sample_wait;
        logic [TICK_W-1:0] sample_tail;
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] disc_tail;
    } swbm_timing_t;

    // dallas crc-8, reflected polynomial 0x8c
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    // a segment lasts at least one tick
    function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] ticks);
        return (ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : ticks;
    endfunction

endpackage

FILE: src/swbm_front.sv
// ============================================================================
// swbm_front: item intake and command queue
// Classifies each accepted item and holds it in a two-entry queue until the
// sequencer takes it.
// ============================================================================
module swbm_front
    import swbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  swbm_item_t  item,
    output swbm_queue_t q_head,
    input  logic        q_take
);

    swbm_cmd_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    swbm_cmd_t  cmd_in;
    logic       wr_en;
    logic       rd_en;

    // op decode
    always_comb
    begin
        cmd_in.tx_byte    = item.tx_byte;
        cmd_in.send_nack  = item.send_nack;
        cmd_in.line_level = item.line_level;
        unique case (item.op)
            OP_TICK:  cmd_in.kind = K_TICK;
            OP_DISC:  cmd_in.kind = K_DISC;
            OP_START: cmd_in.kind = K_START;
            OP_WRITE: cmd_in.kind = K_WRITE;
            OP_READ:  cmd_in.kind = K_READ;
            default:  cmd_in.kind = K_NOP;
        endcase
    end

    assign full         = (cnt_reg == 2'd2);
    assign wr_en        = push && !full;
    assign rd_en        = q_take && (cnt_reg != 2'd0);
    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.cmd   = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: src/swbm_back.sv
// ============================================================================
// swbm_back: bus sequencer and result queue
// Runs the timed segments of each command one tick item at a time and
// places one result per queue entry into a two-entry result queue.
// ============================================================================
module swbm_back
    import swbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  swbm_timing_t timing,
    input  swbm_queue_t  q_head,
    output logic         q_take,
    output logic         empty,
    input  logic         pop,
    output swbm_result_t result
);

    swbm_phase_t       phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]        bidx_reg, bidx_next;
    logic [7:0]        shift_reg, shift_next;
    logic              is_write_reg, is_write_next;
    logic              nack_reg, nack_next;
    logic [7:0]        crc_reg, crc_next;
    logic              drv_reg, drv_next;
    logic [7:0]        rx_reg, rx_next;
    logic              ack_reg, ack_next;
    logic              pres_reg, pres_next;

    // segment entry and finish requests
    logic              ent;
    swbm_phase_t       ent_ph;
    logic [TICK_W-1:0] ent_ticks;
    logic              ent_low;
    logic              fin;
    logic              done;
    logic              rej;
    logic [3:0]        idx_inc;
    logic              data_bit;
    swbm_cmd_t         cmd;

    // result queue
    swbm_result_t      rq_reg [2];
    logic              rq_wr_reg, rq_rd_reg;
    logic [1:0]        rq_cnt_reg;
    swbm_result_t      res_new;
    logic              rq_rd_en;

    assign cmd      = q_head.cmd;
    assign q_take   = q_head.valid && (rq_cnt_reg != 2'd2);
    assign idx_inc  = bidx_reg + 4'd1;
    assign data_bit = is_write_reg ? shift_reg[7] : nack_reg;

    // sequencer next state
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bidx_next     = bidx_reg;
        shift_next    = shift_reg;
        is_write_next = is_write_reg;
        nack_next     = nack_reg;
        crc_next      = crc_reg;
        drv_next      = drv_reg;
        rx_next       = rx_reg;
        ack_next      = ack_reg;
        pres_next     = pres_reg;
        ent           = 1'b0;
        ent_ph        = PH_IDLE;
        ent_ticks     = '0;
        ent_low       = 1'b0;
        fin           = 1'b0;
        done          = 1'b0;
        rej           = 1'b0;

        if (q_take)
        begin
            unique case (cmd.kind)
                K_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (tick_reg > {{(TICK_W-1){1'b0}}, 1'b1})
                        begin
                            tick_next = tick_reg - {{(TICK_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_HOLD:
                                begin
                                    fin  = 1'b1;
                                    done = 1'b1;
                                end
                                PH_DLOW:
                                begin
                                    ent = 1'b1; ent_ph = PH_DREL;
                                    ent_ticks = REL_TICKS; ent_low = 1'b0;
                                end
                                PH_DREL:
                                begin
                                    ent = 1'b1; ent_ph = PH_DPULSE;
                                    ent_ticks = PULSE_TICKS; ent_low = 1'b1;
                                end
                                PH_DPULSE:
                                begin
                                    ent = 1'b1; ent_ph = PH_DWAIT;
                                    ent_ticks = WAIT_TICKS; ent_low = 1'b0;
                                end
                                PH_DWAIT:
                                begin
                                    pres_next = !cmd.line_level;
                                    ent = 1'b1; ent_ph = PH_DTAIL;
                                    ent_ticks = timing.disc_tail; ent_low = 1'b0;
                                end
                                PH_DTAIL:
                                begin
                                    fin  = 1'b1;
                                    done = 1'b1;
                                end
                                PH_BLOW:
                                begin
                                    ent = 1'b1; ent_ph = PH_BDATA;
                                    ent_ticks = timing.zero_low; ent_low = !data_bit;
                                end
                                PH_BDATA:
                                begin
                                    ent = 1'b1; ent_ph = PH_BREC;
                                    ent_ticks = timing.recover; ent_low = 1'b0;
                                end
                                PH_BREC:
                                begin
                                    if (is_write_reg)
                                    begin
                                        shift_next = {shift_reg[6:0], 1'b0};
                                        bidx_next  = idx_inc;
                                        ent        = 1'b1;
                                        ent_ph     = (idx_inc < 4'd8) ? PH_BLOW : PH_SLOW;
                                        ent_ticks  = timing.bit_low;
                                        ent_low    = 1'b1;
                                    end
                                    else
                                    begin
                                        fin  = 1'b1;
                                        done = 1'b1;
                                    end
                                end
                                PH_SLOW:
                                begin
                                    ent = 1'b1; ent_ph = PH_SWAIT;
                                    ent_ticks = timing.sample_wait; ent_low = 1'b0;
                                end
                                PH_SWAIT:
                                begin
                                    if (is_write_reg)
                                    begin
                                        ack_next = cmd.line_level;
                                    end
                                    else
                                    begin
                                        shift_next = {shift_reg[6:0], cmd.line_level};
                                    end
                                    ent = 1'b1; ent_ph = PH_STAIL;
                                    ent_ticks = timing.sample_tail; ent_low = 1'b0;
                                end
                                PH_STAIL:
                                begin
                                    if (is_write_reg)
                                    begin
                                        fin  = 1'b1;
                                        done = 1'b1;
                                    end
                                    else
                                    begin
                                        bidx_next = idx_inc;
                                        ent       = 1'b1;
                                        ent_ticks = timing.bit_low;
                                        ent_low   = 1'b1;
                                        if (idx_inc < 4'd8)
                                        begin
                                            ent_ph = PH_SLOW;
                                        end
                                        else
                                        begin
                                            // byte complete, then the ack frame
                                            rx_next  = shift_reg;
                                            crc_next = crc_update(crc_reg, shift_reg);
                                            ent_ph   = PH_BLOW;
                                        end
                                    end
                                end
                                default:
                                begin
                                    fin = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                K_NOP:
                begin
                end
                default:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        bidx_next     = 4'd0;
                        is_write_next = (cmd.kind == K_WRITE);
                        ent           = 1'b1;
                        unique case (cmd.kind)
                            K_DISC:
                            begin
                                ent_ph = PH_DLOW;
                                ent_ticks = timing.reset_low; ent_low = 1'b1;
                            end
                            K_START:
                            begin
                                crc_next = 8'd0;
                                ent_ph = PH_HOLD;
                                ent_ticks = timing.start_hold; ent_low = 1'b0;
                            end
                            K_WRITE:
                            begin
                                shift_next = cmd.tx_byte;
                                ent_ph = PH_BLOW;
                                ent_ticks = timing.bit_low; ent_low = 1'b1;
                            end
                            default:
                            begin
                                shift_next = 8'd0;
                                nack_next  = cmd.send_nack;
                                ent_ph = PH_SLOW;
                                ent_ticks = timing.bit_low; ent_low = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end

        if (ent)
        begin
            phase_next = ent_ph;
            tick_next  = seg_len(ent_ticks);
            drv_next   = ent_low;
        end
        if (fin)
        begin
            phase_next = PH_IDLE;
            tick_next  = '0;
            drv_next   = 1'b0;
        end
    end

    // result of the item taken this cycle
    always_comb
    begin
        res_new.drive_low    = drv_next;
        res_new.busy_res     = (phase_next != PH_IDLE);
        res_new.done_res     = done;
        res_new.rx_byte      = rx_next;
        res_new.ack_bit      = ack_next;
        res_new.present      = pres_next;
        res_new.crc_value    = crc_next;
        res_new.cmd_rejected = rej;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bidx_reg     <= 4'd0;
            shift_reg    <= 8'd0;
            is_write_reg <= 1'b0;
            nack_reg     <= 1'b0;
            crc_reg      <= 8'd0;
            drv_reg      <= 1'b0;
            rx_reg       <= 8'd0;
            ack_reg      <= 1'b0;
            pres_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bidx_reg     <= bidx_next;
            shift_reg    <= shift_next;
            is_write_reg <= is_write_next;
            nack_reg     <= nack_next;
            crc_reg      <= crc_next;
            drv_reg      <= drv_next;
            rx_reg       <= rx_next;
            ack_reg      <= ack_next;
            pres_reg     <= pres_next;
        end
    end

    // result queue control
    assign empty    = (rq_cnt_reg == 2'd0);
    assign rq_rd_en = pop && !empty;
    assign result   = rq_reg[rq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_reg ^ q_take;
            rq_rd_reg  <= rq_rd_reg ^ rq_rd_en;
            rq_cnt_reg <= rq_cnt_reg + {1'b0, q_take} - {1'b0, rq_rd_en};
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            rq_reg[rq_wr_reg] <= res_new;
        end
    end

endmodule

FILE: src/single_wire_bus_master.sv
// ============================================================================
// single_wire_bus_master: master for a single-wire open-drain eeprom bus
// Register file behind an apb port, a command intake queue and a timed
// bus sequencer that yields one result per accepted item.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  item      in         push / full                swbm_item_t
//  result    out        pop / empty                swbm_result_t
//  config    in         psel penable pwrite pready paddr, pwdata, prdata
//
//  one item per clock sustained while results are popped; each item passes
//  the intake queue before the sequencer writes its result queue entry.
//  the sequencer takes a queued item only while the result queue has room,
//  so a stalled pop backs up into full after four items.
//  rst_n resets the queues, the sequencer and the timing registers at once.
//
module single_wire_bus_master
    import swbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  swbm_item_t        item,
    output logic              empty,
    input  logic              pop,
    output swbm_result_t      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [TICK_W-1:0]    cfg_reg [NUM_CFG];
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    swbm_timing_t         timing;
    swbm_queue_t          q_head;
    logic                 q_take;

    // apb register access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = {{(32-TICK_W){1'b0}}, cfg_reg[cfg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr)
        begin
            cfg_reg[cfg_idx] <= pwdata[TICK_W-1:0];
        end
    end

    // timing set for the sequencer
    assign timing.start_hold  = cfg_reg[CFG_START_HOLD];
    assign timing.bit_low     = cfg_reg[CFG_BIT_LOW];
    assign timing.zero_low    = cfg_reg[CFG_ZERO_LOW];
    assign timing.recover     = cfg_reg[CFG_RECOVER];
    assign timing.sample_wait = cfg_reg[CFG_SAMPLE_WAIT];
    assign timing.sample_tail = cfg_reg[CFG_SAMPLE_TAIL];
    assign timing.reset_low   = cfg_reg[CFG_RESET_LOW];
    assign timing.disc_tail   = cfg_reg[CFG_DISC_TAIL];

    // command intake
    swbm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_head (q_head),
        .q_take (q_take)
    );

    // bus sequencer
    swbm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .timing (timing),
        .q_head (q_head),
        .q_take (q_take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

FILE: src/swbm_checker.sv
// ============================================================================
// swbm_checker: port-level checks of the single-wire bus master
// Watches the result port for combinations the sequencer can never produce.
// ============================================================================
module swbm_checker
    import swbm_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         empty,
    input logic         pop,
    input swbm_result_t result
);

    // a finishing transaction always leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> !result.busy_res)
        else $error("done result while still busy");

    // a rejected command only happens while a command runs
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.cmd_rejected) |-> result.busy_res)
        else $error("rejected command while idle");

    // an idle sequencer never holds the line low
    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.busy_res) |-> !result.drive_low)
        else $error("line driven while idle");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed without pop");

endmodule

bind single_wire_bus_master swbm_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: tb/single_wire_bus_master_tb.sv
// ============================================================================
// single_wire_bus_master_tb: self-checking bench of the single-wire bus master
// Feeds commands and line-level ticks through the item queue, mirrors the bus
// sequencer in a local model and compares every popped result field by field.
// Timing registers are programmed over apb between traffic phases and read
// back, from all-zero up to full scale, with random stalls on both queues.
// ============================================================================
`timescale 1ns / 100ps

module single_wire_bus_master_tb;

    import swbm_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          CYCLE_LIMIT  = 100_000;
    localparam int          PRINT_LIMIT  = 20;
    localparam int          HOLD_CYCLES  = 300;
    // highest op code, ignored like the two below it
    localparam logic [2:0]  OP_LAST_CODE = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    swbm_item_t        item = '0;
    logic              empty;
    logic              pop = 1'b0;
    swbm_result_t      result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    single_wire_bus_master i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // stimulus and scoreboard bookkeeping
    swbm_item_t   pending_items[$];
    swbm_result_t bus_results_due[$];
    swbm_result_t oldest;
    int           sent_count = 0;
    int           accepted_count = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    logic         handed_over = 1'b0;
    logic         bursty = 1'b0;
    int           tx_gap = 0;
    int           rx_gap = 0;
    int           hold_left = 0;
    int           pressure_mark = -1;
    logic         pressure_done = 1'b0;

    // timing registers as programmed
    logic [TICK_W-1:0] tick_cfg [NUM_CFG];

    // sequencer mirror
    swbm_phase_t       seq_phase = PH_IDLE;
    logic [TICK_W-1:0] seg_left = '0;
    logic [3:0]        bits_done = '0;
    logic [7:0]        shreg = '0;
    logic [2:0]        cmd_op = OP_TICK;
    logic              nack_hold = 1'b0;
    logic [7:0]        crc_acc = '0;
    logic              pulling_low = 1'b0;
    logic [7:0]        rx_last = '0;
    logic              ack_last = 1'b0;
    logic              presence_seen = 1'b0;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("mismatch %s: got %0h want %0h (transaction %0d, t=%0t)",
                     what, got, want, accepted_count, $realtime);
        end
    endtask

    // a segment lasts at least one tick
    function automatic int seg_span(logic [TICK_W-1:0] ticks);
        return (ticks == '0) ? 1 : int'(ticks);
    endfunction

    // dallas crc-8, one data bit at a time, lsb first
    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int b = 0; b < 8; b++)
        begin
            fb = c[0] ^ data[b];
            c = c >> 1;
            if (fb)
                c = c ^ 8'h8C;
        end
        return c;
    endfunction

    function automatic void enter_segment(swbm_phase_t ph, logic [TICK_W-1:0] ticks,
                                          logic low);
        seq_phase   = ph;
        seg_left    = TICK_W'(seg_span(ticks));
        pulling_low = low;
    endfunction

    function automatic void go_idle();
        seq_phase   = PH_IDLE;
        seg_left    = '0;
        pulling_low = 1'b0;
    endfunction

    // closes the running segment, returns 1 when the command completes
    function automatic logic end_segment(logic level);
        logic data_bit;
        case (seq_phase)
            PH_HOLD, PH_DTAIL:
            begin
                go_idle();
                return 1'b1;
            end
            PH_DLOW:   enter_segment(PH_DREL, REL_TICKS, 1'b0);
            PH_DREL:   enter_segment(PH_DPULSE, PULSE_TICKS, 1'b1);
            PH_DPULSE: enter_segment(PH_DWAIT, WAIT_TICKS, 1'b0);
            PH_DWAIT:
            begin
                presence_seen = ~level;
                enter_segment(PH_DTAIL, tick_cfg[CFG_DISC_TAIL], 1'b0);
            end
            PH_BLOW:
            begin
                data_bit = (cmd_op == OP_WRITE) ? shreg[7] : nack_hold;
                enter_segment(PH_BDATA, tick_cfg[CFG_ZERO_LOW], ~data_bit);
            end
            PH_BDATA:  enter_segment(PH_BREC, tick_cfg[CFG_RECOVER], 1'b0);
            PH_BREC:
            begin
                if (cmd_op != OP_WRITE)
                begin
                    go_idle();
                    return 1'b1;
                end
                shreg     = shreg << 1;
                bits_done = bits_done + 4'd1;
                enter_segment((bits_done < 4'd8) ? PH_BLOW : PH_SLOW,
                              tick_cfg[CFG_BIT_LOW], 1'b1);
            end
            PH_SLOW:   enter_segment(PH_SWAIT, tick_cfg[CFG_SAMPLE_WAIT], 1'b0);
            PH_SWAIT:
            begin
                if (cmd_op == OP_WRITE)
                    ack_last = level;
                else
                    shreg = {shreg[6:0], level};
                enter_segment(PH_STAIL, tick_cfg[CFG_SAMPLE_TAIL], 1'b0);
            end
            PH_STAIL:
            begin
                if (cmd_op == OP_WRITE)
                begin
                    go_idle();
                    return 1'b1;
                end
                bits_done = bits_done + 4'd1;
                if (bits_done < 4'd8)
                begin
                    enter_segment(PH_SLOW, tick_cfg[CFG_BIT_LOW], 1'b1);
                end
                else
                begin
                    // byte complete, then the ack or nack bit frame
                    rx_last = shreg;
                    crc_acc = crc8_step(crc_acc, shreg);
                    enter_segment(PH_BLOW, tick_cfg[CFG_BIT_LOW], 1'b1);
                end
            end
            default:   go_idle();
        endcase
        return 1'b0;
    endfunction

    // next result of the sequencer for one accepted item
    function automatic swbm_result_t sequencer_step(swbm_item_t it);
        swbm_result_t r;
        logic         done;
        logic         rejected;
        done     = 1'b0;
        rejected = 1'b0;
        if (it.op == OP_TICK)
        begin
            if (seq_phase != PH_IDLE)
            begin
                if (seg_left > TICK_W'(1))
                    seg_left = seg_left - TICK_W'(1);
                else
                    done = end_segment(it.line_level);
            end
        end
        else if (it.op <= OP_READ)
        begin
            if (seq_phase != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                cmd_op    = it.op;
                bits_done = '0;
                case (it.op)
                    OP_DISC:
                        enter_segment(PH_DLOW, tick_cfg[CFG_RESET_LOW], 1'b1);
                    OP_START:
                    begin
                        crc_acc = '0;
                        enter_segment(PH_HOLD, tick_cfg[CFG_START_HOLD], 1'b0);
                    end
                    OP_WRITE:
                    begin
                        shreg = it.tx_byte;
                        enter_segment(PH_BLOW, tick_cfg[CFG_BIT_LOW], 1'b1);
                    end
                    default:
                    begin
                        shreg     = '0;
                        nack_hold = it.send_nack;
                        enter_segment(PH_SLOW, tick_cfg[CFG_BIT_LOW], 1'b1);
                    end
                endcase
            end
        end
        r.drive_low    = pulling_low;
        r.busy_res     = (seq_phase != PH_IDLE);
        r.done_res     = done;
        r.rx_byte      = rx_last;
        r.ack_bit      = ack_last;
        r.present      = presence_seen;
        r.crc_value    = crc_acc;
        r.cmd_rejected = rejected;
        return r;
    endfunction

    // ticks a command needs from load to completion
    function automatic int command_ticks(logic [2:0] op);
        int bl;
        int zl;
        int rc;
        int sw;
        int st;
        bl = seg_span(tick_cfg[CFG_BIT_LOW]);
        zl = seg_span(tick_cfg[CFG_ZERO_LOW]);
        rc = seg_span(tick_cfg[CFG_RECOVER]);
        sw = seg_span(tick_cfg[CFG_SAMPLE_WAIT]);
        st = seg_span(tick_cfg[CFG_SAMPLE_TAIL]);
        case (op)
            OP_DISC:
                return seg_span(tick_cfg[CFG_RESET_LOW]) + int'(REL_TICKS)
                       + int'(PULSE_TICKS) + int'(WAIT_TICKS)
                       + seg_span(tick_cfg[CFG_DISC_TAIL]);
            OP_START: return seg_span(tick_cfg[CFG_START_HOLD]);
            OP_WRITE: return 8 * (bl + zl + rc) + bl + sw + st;
            OP_READ:  return 8 * (bl + sw + st) + bl + zl + rc;
            default:  return 0;
        endcase
    endfunction

    function automatic void offer(logic [2:0] op, logic [7:0] txb, logic nack, logic level);
        swbm_item_t it;
        it.op         = op;
        it.tx_byte    = txb;
        it.send_nack  = nack;
        it.line_level = level;
        pending_items.push_back(it);
        sent_count++;
    endfunction

    function automatic void offer_tick();
        offer(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // a command and the ticks that carry it to completion, with stray
    // commands slipped in while it runs; returns the items queued
    function automatic int queue_command(logic [2:0] op, logic [7:0] txb, logic nack,
                                         int stray_rate);
        int n;
        int count;
        n     = command_ticks(op);
        count = 1;
        offer(op, txb, nack, 1'($urandom_range(0, 1)));
        for (int k = 0; k < n; k++)
        begin
            if (stray_rate != 0 && $urandom_range(1, stray_rate) == 1)
            begin
                offer(3'($urandom_range(OP_DISC, OP_READ)), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                count++;
            end
            offer_tick();
            count++;
        end
        return count;
    endfunction

    // mostly whole commands, some idle ticks and unused op codes
    function automatic void random_traffic(int target);
        int busy_items;
        int pick;
        busy_items = 0;
        while (busy_items < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                if (pick == 0)
                    offer_tick();
                else
                    offer(3'($urandom_range(OP_READ + 1, OP_LAST_CODE)), 8'($urandom),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 3)
                busy_items += queue_command(OP_DISC, 8'($urandom), 1'($urandom_range(0, 1)), 40);
            else if (pick < 7)
                busy_items += queue_command(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 3);
            else if (pick < 13)
                busy_items += queue_command(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 20);
            else
                busy_items += queue_command(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 20);
        end
    endfunction

    task automatic cfg_write(int idx, logic [TICK_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * idx);
        pwdata  <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tick_cfg[idx] = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read(int idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_AW'(4 * idx);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'h0, tick_cfg[idx]})
            flag_mismatch("register readback", prdata, {16'h0, tick_cfg[idx]});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // program every timing register within [lo, hi] and read all back
    task automatic load_timing(int lo, int hi);
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_write(i, TICK_W'($urandom_range(lo, hi)));
        end
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_read(i);
        end
        @(posedge clk);
    endtask

    // wait until every queued item is in and every result is out
    task automatic settle();
        do @(negedge clk); while (accepted_count != sent_count || bus_results_due.size() != 0);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    // drain, and tick on until the sequencer is back in idle
    task automatic close_phase();
        settle();
        while (seq_phase != PH_IDLE)
        begin
            offer_tick();
            settle();
        end
    endtask

    // accepted items feed the model, popped results are checked
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("single_wire_bus_master_tb failed");
            $finish;
        end
        handed_over = rst_n && push && !full;
        if (handed_over)
        begin
            bus_results_due.push_back(sequencer_step(item));
            accepted_count++;
        end
        if (rst_n && pop && !empty)
        begin
            if (bus_results_due.size() == 0)
            begin
                flag_mismatch("result with none expected", 32'(result), '0);
            end
            else
            begin
                oldest = bus_results_due.pop_front();
                if (result.drive_low !== oldest.drive_low)
                    flag_mismatch("drive_low", 32'(result.drive_low),
                                  32'(oldest.drive_low));
                if (result.busy_res !== oldest.busy_res)
                    flag_mismatch("busy_res", 32'(result.busy_res),
                                  32'(oldest.busy_res));
                if (result.done_res !== oldest.done_res)
                    flag_mismatch("done_res", 32'(result.done_res),
                                  32'(oldest.done_res));
                if (result.rx_byte !== oldest.rx_byte)
                    flag_mismatch("rx_byte", 32'(result.rx_byte), 32'(oldest.rx_byte));
                if (result.ack_bit !== oldest.ack_bit)
                    flag_mismatch("ack_bit", 32'(result.ack_bit), 32'(oldest.ack_bit));
                if (result.present !== oldest.present)
                    flag_mismatch("present", 32'(result.present), 32'(oldest.present));
                if (result.crc_value !== oldest.crc_value)
                    flag_mismatch("crc_value", 32'(result.crc_value),
                                  32'(oldest.crc_value));
                if (result.cmd_rejected !== oldest.cmd_rejected)
                    flag_mismatch("cmd_rejected", 32'(result.cmd_rejected),
                                  32'(oldest.cmd_rejected));
            end
        end
    end

    // item driver: holds a transaction until taken, random gaps when bursty
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push && !handed_over)
        begin
            // still waiting for room
        end
        else if (tx_gap > 0)
        begin
            push <= 1'b0;
            tx_gap--;
        end
        else if (pending_items.size() > 0)
        begin
            item <= pending_items.pop_front();
            push <= 1'b1;
            if (bursty && $urandom_range(0, 5) == 0)
                tx_gap = $urandom_range(1, 8);
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // result receiver: random gaps, one long hold-off to back up the queues
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (!pressure_done && accepted_count == pressure_mark)
        begin
            pop <= 1'b0;
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end
        else if (rx_gap > 0)
        begin
            pop <= 1'b0;
            rx_gap--;
        end
        else
        begin
            pop <= 1'b1;
            if (bursty && $urandom_range(0, 5) == 0)
                rx_gap = $urandom_range(1, 8);
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_CFG; i++)
        begin
            tick_cfg[i] = CFG_RESET[i];
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the timing registers
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_read(i);
        end
        @(posedge clk);
        bursty = 1'b1;

        // short timing so that whole commands stay brief
        load_timing(1, 3);

        // idle ticks, unused op codes, commands while busy
        offer(OP_TICK, 8'h00, 1'b0, 1'b0);
        offer(OP_TICK, 8'hFF, 1'b1, 1'b1);
        for (int o = OP_READ + 1; o <= OP_LAST_CODE; o++)
        begin
            offer(3'(o), 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        offer(OP_START, 8'h00, 1'b0, 1'b0);
        offer(OP_DISC, 8'h00, 1'b0, 1'b1);
        offer(OP_START, 8'h00, 1'b1, 1'b0);
        offer(OP_WRITE, 8'hFF, 1'b0, 1'b0);
        offer(OP_READ, 8'h00, 1'b1, 1'b1);
        for (int k = 0; k < command_ticks(OP_START); k++)
        begin
            offer_tick();
        end
        void'(queue_command(OP_WRITE, 8'h5A, 1'b0, 0));
        void'(queue_command(OP_READ, 8'h00, 1'b1, 0));
        close_phase();

        // all-zero timing: every programmable segment one tick long
        load_timing(0, 0);
        void'(queue_command(OP_WRITE, 8'h00, 1'b0, 0));
        void'(queue_command(OP_READ, 8'hFF, 1'b1, 8));
        void'(queue_command(OP_DISC, 8'h00, 1'b0, 30));
        void'(queue_command(OP_START, 8'h00, 1'b0, 0));
        random_traffic(20);
        close_phase();

        // short timing, steady flow, receiver holds off once
        load_timing(1, 3);
        bursty = 1'b0;
        pressure_mark = accepted_count + 40;
        random_traffic(80);
        close_phase();

        // mixed short timing with bursts on both sides
        load_timing(0, 2);
        bursty = 1'b1;
        random_traffic(40);
        close_phase();

        // full-scale timing, no idling: the opening of a long hold
        load_timing(int'({TICK_W{1'b1}}), int'({TICK_W{1'b1}}));
        bursty = 1'b0;
        offer(OP_START, 8'h00, 1'b0, 1'b0);
        for (int k = 0; k < 20; k++)
        begin
            if (k == 10)
                offer(OP_WRITE, 8'hA5, 1'b0, 1'b0);
            offer_tick();
        end
        settle();

        if (error_count == 0)
            $display("single_wire_bus_master_tb passed");
        else
            $display("single_wire_bus_master_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/swbm_pkg.sv
src/swbm_front.sv
src/swbm_back.sv
src/single_wire_bus_master.sv
src/swbm_checker.sv
tb/single_wire_bus_master_tb.sv
